@@ rtl/vector_distance_metric_unit_macros.svh @@
// assertion macros used by the distance unit rtl (vdm_queue)
// expects clk and rst_n in the scope where a macro is used
`ifndef VECTOR_DISTANCE_METRIC_UNIT_MACROS_SVH
`define VECTOR_DISTANCE_METRIC_UNIT_MACROS_SVH

// cons must hold in the same cycle whenever ante holds
`define VDM_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// cond must hold at every clock edge out of reset
`define VDM_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

`endif

@@ rtl/vdm_pkg.sv @@
// shared types and constants for the vector distance unit
// no dependencies
package vdm_pkg;

    localparam int FEAT_W        = 16;  // port width of one feature
    localparam int FEATURE_WIDTH = 16;  // bits of a feature that are used, 8..16
    localparam int DIFF_W        = 17;
    localparam int SQ_W          = 2 * DIFF_W;
    localparam int SUM_W         = 44;
    localparam int DIST_W        = 27;
    localparam int ROOT_STEPS    = SUM_W / 2;

    localparam logic [SUM_W-1:0]  SUM_MAX  = {SUM_W{1'b1}};
    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    localparam logic [1:0] METRIC_MANHATTAN = 2'd0;
    localparam logic [1:0] METRIC_EUCLIDEAN = 2'd1;
    localparam logic [1:0] METRIC_CHEBYSHEV = 2'd2;

    // apb register map
    localparam int   PADDR_W    = 3;
    localparam int   PDATA_W    = 32;
    localparam logic REG_METRIC = 1'b0;

    // job queue between the front and back parts
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic [1:0]        metric;
        logic [SUM_W-1:0]  sum;
        logic [DIFF_W-1:0] maxd;
        logic              ovf;
    } job_t;

endpackage

@@ rtl/vdm_queue.sv @@
// two-entry job queue between accumulator front and result back
// uses vdm_pkg and the assertion macro header
`include "vector_distance_metric_unit_macros.svh"

module vdm_queue
    import vdm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  job_t              push_job,
    input  logic              pop,
    output logic              head_valid,
    output job_t              head_job,
    output logic [QCNT_W-1:0] count
);

    job_t              mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = push ? QPTR_W'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = pop ? QPTR_W'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = QCNT_W'(count_reg + 1'b1);
        end
        else if (pop && !push)
        begin
            count_next = QCNT_W'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    assign head_valid = (count_reg != '0);
    assign head_job   = mem_reg[rd_ptr_reg];
    assign count      = count_reg;

    `VDM_ASSERT_IMPLY(a_no_push_full, push, count_reg != QCNT_W'(QDEPTH), "job pushed into full queue")
    `VDM_ASSERT_IMPLY(a_no_pop_empty, pop, count_reg != '0, "job popped from empty queue")
    `VDM_ASSERT_ALWAYS(a_count_bound, count_reg <= QCNT_W'(QDEPTH), "queue count past depth")

endmodule

@@ rtl/vdm_front.sv @@
// front part: takes element pairs and accumulates the running metric
// uses vdm_pkg; hands finished vectors to the job queue
module vdm_front
    import vdm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [1:0]        metric,
    input  logic              pair_valid,
    output logic              pair_stall,
    input  logic [FEAT_W-1:0] feature_a,
    input  logic [FEAT_W-1:0] feature_b,
    input  logic              last_pair,
    input  logic [QCNT_W-1:0] q_count,
    output logic              push,
    output job_t              push_job
);

    function automatic logic signed [DIFF_W-1:0] to_feature(input logic [FEAT_W-1:0] raw);
        logic [FEATURE_WIDTH-1:0] v;
        v = raw[FEATURE_WIDTH-1:0];
        return {{(DIFF_W - FEATURE_WIDTH){v[FEATURE_WIDTH-1]}}, v};
    endfunction

    logic                     accept;
    logic signed [DIFF_W-1:0] diff;
    logic [DIFF_W-1:0]        abs_diff;
    logic [QCNT_W:0]          q_demand;

    // pair stage
    logic              a_vld_reg, a_vld_next;
    logic [DIFF_W-1:0] a_ad_reg;
    logic [1:0]        a_metric_reg;
    logic              a_last_reg;

    // accumulators
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [DIFF_W-1:0] maxd_reg, maxd_next;
    logic              ovf_reg, ovf_next;

    logic [SQ_W-1:0]   square;
    logic [SQ_W-1:0]   addend;
    logic [SUM_W:0]    sum_wide;
    logic [SUM_W-1:0]  sum_upd;
    logic [DIFF_W-1:0] maxd_upd;
    logic              ovf_upd;

    // a pair held in the pair stage may still push, so leave room for it and one more
    assign q_demand   = (QCNT_W+1)'(q_count) + (QCNT_W+1)'(a_vld_reg && a_last_reg);
    assign pair_stall = (q_demand >= (QCNT_W+1)'(QDEPTH));
    assign accept     = pair_valid && !pair_stall;

    assign diff       = to_feature(feature_a) - to_feature(feature_b);
    assign abs_diff   = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
    assign a_vld_next = accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
        end
        else
        begin
            a_vld_reg <= a_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_ad_reg     <= abs_diff;
            a_metric_reg <= metric;
            a_last_reg   <= last_pair;
        end
    end

    assign square = a_ad_reg * a_ad_reg;

    always_comb
    begin
        case (a_metric_reg)
            METRIC_MANHATTAN: addend = SQ_W'(a_ad_reg);
            METRIC_EUCLIDEAN: addend = square;
            default:          addend = '0;
        endcase
        sum_wide = {1'b0, sum_reg} + (SUM_W+1)'(addend);
        sum_upd  = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
        ovf_upd  = ovf_reg | sum_wide[SUM_W];
        maxd_upd = maxd_reg;
        if (a_metric_reg == METRIC_CHEBYSHEV && a_ad_reg > maxd_reg)
        begin
            maxd_upd = a_ad_reg;
        end

        sum_next  = sum_reg;
        maxd_next = maxd_reg;
        ovf_next  = ovf_reg;
        if (a_vld_reg)
        begin
            if (a_last_reg)
            begin
                sum_next  = '0;
                maxd_next = '0;
                ovf_next  = 1'b0;
            end
            else
            begin
                sum_next  = sum_upd;
                maxd_next = maxd_upd;
                ovf_next  = ovf_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg  <= '0;
            maxd_reg <= '0;
            ovf_reg  <= 1'b0;
        end
        else
        begin
            sum_reg  <= sum_next;
            maxd_reg <= maxd_next;
            ovf_reg  <= ovf_next;
        end
    end

    assign push            = a_vld_reg && a_last_reg;
    assign push_job.metric = a_metric_reg;
    assign push_job.sum    = sum_upd;
    assign push_job.maxd   = maxd_upd;
    assign push_job.ovf    = ovf_upd;

endmodule

@@ rtl/vdm_back.sv @@
// back part: turns a finished vector into a distance, with a bitwise square root
// uses vdm_pkg; drives the result channel through an output register
module vdm_back
    import vdm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              head_valid,
    input  job_t              head_job,
    output logic              pop,
    output logic              result_valid,
    input  logic              result_stall,
    output logic [DIST_W-1:0] distance,
    output logic              saturated
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_ROOT = 3'b010,
        ST_DONE = 3'b100
    } back_state_t;

    back_state_t state_reg, state_next;

    logic [SUM_W-1:0]  op_reg, op_next;
    logic [SUM_W-1:0]  res_reg, res_next;
    logic [SUM_W-1:0]  bit_reg, bit_next;
    logic              rsat_reg, rsat_next;

    logic              out_valid_reg, out_valid_next;
    logic [DIST_W-1:0] out_dist_reg, out_dist_next;
    logic              out_sat_reg, out_sat_next;

    logic              out_free;
    logic              load;
    logic [DIST_W-1:0] load_dist;
    logic              load_sat;
    logic [DIST_W-1:0] direct_dist;
    logic              direct_sat;
    logic [SUM_W-1:0]  trial;

    assign out_free = !out_valid_reg || !result_stall;
    assign trial    = res_reg + bit_reg;

    // results that need no root
    always_comb
    begin
        direct_sat = head_job.ovf;
        case (head_job.metric)
            METRIC_MANHATTAN:
            begin
                if (head_job.sum > SUM_W'(DIST_MAX))
                begin
                    direct_dist = DIST_MAX;
                    direct_sat  = 1'b1;
                end
                else
                begin
                    direct_dist = head_job.sum[DIST_W-1:0];
                end
            end
            METRIC_CHEBYSHEV: direct_dist = DIST_W'(head_job.maxd);
            default:          direct_dist = '0;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        res_next   = res_reg;
        bit_next   = bit_reg;
        rsat_next  = rsat_reg;
        pop        = 1'b0;
        load       = 1'b0;
        load_dist  = direct_dist;
        load_sat   = direct_sat;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (head_valid)
                begin
                    if (head_job.metric == METRIC_EUCLIDEAN)
                    begin
                        pop        = 1'b1;
                        op_next    = head_job.sum;
                        res_next   = '0;
                        bit_next   = SUM_W'(1) << (2 * (ROOT_STEPS - 1));
                        rsat_next  = head_job.ovf;
                        state_next = ST_ROOT;
                    end
                    else if (out_free)
                    begin
                        pop  = 1'b1;
                        load = 1'b1;
                    end
                end
            end
            ST_ROOT:
            begin
                // one result bit per cycle
                if (op_reg >= trial)
                begin
                    op_next  = op_reg - trial;
                    res_next = (res_reg >> 1) + bit_reg;
                end
                else
                begin
                    res_next = res_reg >> 1;
                end
                bit_next = bit_reg >> 2;
                if (bit_reg == SUM_W'(1))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                load_dist = res_reg[DIST_W-1:0];
                load_sat  = rsat_reg;
                if (out_free)
                begin
                    load       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        out_valid_next = out_valid_reg && result_stall;
        out_dist_next  = out_dist_reg;
        out_sat_next   = out_sat_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
            out_dist_next  = load_dist;
            out_sat_next   = load_sat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        res_reg      <= res_next;
        bit_reg      <= bit_next;
        rsat_reg     <= rsat_next;
        out_dist_reg <= out_dist_next;
        out_sat_reg  <= out_sat_next;
    end

    assign result_valid = out_valid_reg;
    assign distance     = out_dist_reg;
    assign saturated    = out_sat_reg;

endmodule

@@ rtl/vector_distance_metric_unit.sv @@
// Vector distance unit. Element pairs stream in at one item per clock while pair_stall is low;
// each vector ends with the pair marked last_pair, and one result (distance, saturated)
// follows per vector. The metric register (apb offset 0) picks Manhattan, Euclidean or
// Chebyshev. A pair's difference is registered in the difference stage and then accumulated;
// for Manhattan and Chebyshev the finished vector passes through the job queue to the output
// register. A Euclidean result also goes through the bit-serial square root before it loads
// the output register, and the root handles one vector at a time. A two-entry job queue sits
// between accumulation and result generation, so pairs of the next vectors keep flowing while
// a root is in progress; pair_stall rises only when that queue is full or about to be.
// top level: apb register, front accumulator, job queue and result back end
// uses vdm_pkg, vdm_front, vdm_queue, vdm_back
module vector_distance_metric_unit
    import vdm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    input  logic               pair_valid,
    output logic               pair_stall,
    input  logic [FEAT_W-1:0]  feature_a,
    input  logic [FEAT_W-1:0]  feature_b,
    input  logic               last_pair,
    output logic               result_valid,
    input  logic               result_stall,
    output logic [DIST_W-1:0]  distance,
    output logic               saturated
);

    logic [1:0]        metric_reg, metric_next;
    logic              reg_sel;
    logic              push;
    job_t              push_job;
    logic              pop;
    logic              head_valid;
    job_t              head_job;
    logic [QCNT_W-1:0] q_count;

    assign pready  = 1'b1;
    assign reg_sel = paddr[PADDR_W-1];

    always_comb
    begin
        metric_next = metric_reg;
        if (psel && penable && pwrite && reg_sel == REG_METRIC)
        begin
            metric_next = pwdata[1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            metric_reg <= METRIC_MANHATTAN;
        end
        else
        begin
            metric_reg <= metric_next;
        end
    end

    assign prdata = (reg_sel == REG_METRIC) ? PDATA_W'(metric_reg) : '0;

    vdm_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .metric     (metric_reg),
        .pair_valid (pair_valid),
        .pair_stall (pair_stall),
        .feature_a  (feature_a),
        .feature_b  (feature_b),
        .last_pair  (last_pair),
        .q_count    (q_count),
        .push       (push),
        .push_job   (push_job)
    );

    vdm_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .pop        (pop),
        .head_valid (head_valid),
        .head_job   (head_job),
        .count      (q_count)
    );

    vdm_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (head_valid),
        .head_job     (head_job),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .distance     (distance),
        .saturated    (saturated)
    );

endmodule
